>>> sv/particle_landmark_weight_assert.svh
// assertion macros for the particle landmark weight block
// used by the top level only; no other dependencies
`ifndef PARTICLE_LANDMARK_WEIGHT_ASSERT_SVH
`define PARTICLE_LANDMARK_WEIGHT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define PLW_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define PLW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/plw_pkg.sv
// shared constants, field layout and control types for particle_landmark_weight
// no dependencies; used by every module of the block but plw_ram
package plw_pkg;

    // table and coordinate sizing
    localparam int MAX_LANDMARKS = 64;
    localparam int COORD_BITS    = 24;
    localparam int ADDR_BITS     = $clog2(MAX_LANDMARKS);
    localparam int COUNT_BITS    = $clog2(MAX_LANDMARKS + 1);

    // heading and transform arithmetic
    localparam int HEAD_BITS  = 16;
    localparam int FRAC_BITS  = 14;
    localparam int PROD_BITS  = COORD_BITS + HEAD_BITS;
    localparam int SHIFT_BITS = PROD_BITS + 2 - FRAC_BITS;
    localparam int MAP_BITS   = SHIFT_BITS + 1;
    localparam int DIFF_BITS  = MAP_BITS + 1;

    // distance arithmetic, differences clamped to 2^21
    localparam int CLAMP_BITS = 22;
    localparam int SQ_BITS    = 2 * CLAMP_BITS;
    localparam int DIST_BITS  = SQ_BITS + 1;

    // configuration register widths
    localparam int LCOUNT_BITS = 7;
    localparam int RANGE_BITS  = 41;
    localparam int COEF_BITS   = 16;
    localparam int LOG_BITS    = 32;

    // scoring arithmetic
    localparam int SCORE_SHIFT = 24;
    localparam int SPROD_BITS  = SQ_BITS + COEF_BITS;
    localparam int QSUM_BITS   = SPROD_BITS + 1;
    localparam int Q_BITS      = QSUM_BITS - SCORE_SHIFT;
    localparam int WIDE_BITS   = Q_BITS + 3;
    localparam logic [QSUM_BITS-1:0] ROUND_HALF = QSUM_BITS'(1) << (SCORE_SHIFT - 1);

    // configuration port
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = RANGE_BITS;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LANDMARK_COUNT = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RANGE_SQUARED  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_X         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_COEF_Y         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOG_NORM       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MISS_PENALTY   = 3'd5;
    localparam logic signed [LOG_BITS-1:0] MISS_PENALTY_RESET = -32'sd181352;

    // request kinds carried in tuser
    localparam int OP_BITS = 2;
    localparam logic [OP_BITS-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_BITS-1:0] OP_POSE = 2'd1;
    localparam logic [OP_BITS-1:0] OP_OBS  = 2'd2;

    // input tdata layout
    localparam int SLOT_BITS     = 6;
    localparam int SLOT_LSB      = 0;
    localparam int MARK_X_LSB    = SLOT_LSB + SLOT_BITS;
    localparam int MARK_Y_LSB    = MARK_X_LSB + COORD_BITS;
    localparam int POSE_X_LSB    = MARK_Y_LSB + COORD_BITS;
    localparam int POSE_Y_LSB    = POSE_X_LSB + COORD_BITS;
    localparam int COS_LSB       = POSE_Y_LSB + COORD_BITS;
    localparam int SIN_LSB       = COS_LSB + HEAD_BITS;
    localparam int OBS_X_LSB     = SIN_LSB + HEAD_BITS;
    localparam int OBS_Y_LSB     = OBS_X_LSB + COORD_BITS;
    localparam int IN_FIELD_BITS = OBS_Y_LSB + COORD_BITS;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_INDEX_LSB  = 0;
    localparam int OUT_WEIGHT_LSB = OUT_INDEX_LSB + SLOT_BITS;
    localparam int OUT_FIELD_BITS = OUT_WEIGHT_LSB + LOG_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    // controller to datapath
    typedef struct packed {
        logic                 accept;
        logic                 xform_en;
        logic                 issue;
        logic [ADDR_BITS-1:0] issue_addr;
        logic                 score_en;
        logic                 load_out;
    } plw_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [COUNT_BITS-1:0] scan_count;
        logic                  pipe_busy;
    } plw_status_t;

endpackage

>>> sv/particle_landmark_weight.sv
// top level of the particle landmark weight block
// depends on plw_pkg, plw_ctrl, plw_datapath, plw_ram and the assertion header
//
// usage:
//  - config port: cfg_wr_en, cfg_index, cfg_wr_data write one register per
//    cycle; 0 landmark count, 1 range squared, 2 coef x, 3 coef y, 4 log norm,
//    5 miss penalty; other indexes are ignored; write only while idle
//  - input stream s_*: tuser carries the request kind (load landmark, start
//    pose, observation), tlast marks a particle's final observation
//  - output stream m_*: one result per observation; tuser is the found flag,
//    tlast copies the final-observation mark
//  - load and pose requests give no result
//  - an observation goes from accept to result register through a transform,
//    a scan of the n searched landmarks (n up to 64) with one table read per
//    cycle through the single read port of the landmark ram, a three stage clamp,
//    square and compare pipeline, and scoring; the scan is skipped when n is zero
//  - the input is not ready while an observation is at work; a finished
//    result waits in the output register and the next request is taken
//  - if the receiver stalls, a following observation holds in its last
//    cycle until the output register frees
//  - reset (aresetn low, synchronous) clears config to defaults, pose and
//    log-weight to zero; table contents stay undefined until loaded
`include "particle_landmark_weight_assert.svh"

module particle_landmark_weight (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [plw_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [plw_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    // request stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // landmark_slot, mark_x, mark_y, pose_x, pose_y, cos_heading,
    // sin_heading, obs_x, obs_y, zero pad
    input  logic [plw_pkg::IN_DATA_BITS-1:0]   s_tdata,
    // op
    input  logic [plw_pkg::OP_BITS-1:0]        s_tuser,
    input  logic                               s_tlast,
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // landmark_index, log_weight, zero pad
    output logic [plw_pkg::OUT_DATA_BITS-1:0]  m_tdata,
    // found
    output logic [0:0]                         m_tuser,
    output logic                               m_tlast
);

    plw_pkg::plw_cmd_t    cmd;
    plw_pkg::plw_status_t status;

    // sequencing, handshakes and output valid
    plw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_op     (s_tuser),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    // config, landmark table, transform, scan and scoring
    plw_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_op        (s_tuser),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .cmd         (cmd),
        .status      (status),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    // the scan pipeline is empty whenever a new request can be taken
    `PLW_ASSERT_SAME(a_ready_pipe_empty, aclk, aresetn, s_tready, !status.pipe_busy, "ready with scan in flight")

    // a result is only written into a free output register
    `PLW_ASSERT_SAME(a_load_free, aclk, aresetn, cmd.load_out, (!m_tvalid || m_tready), "result overwrite")

    // an accepted observation blocks the input on the next cycle
    `PLW_ASSERT_NEXT(a_obs_blocks, aclk, aresetn, (s_tvalid && s_tready && (s_tuser == plw_pkg::OP_OBS)), !s_tready, "ready after observation")

    // a miss reports slot zero
    `PLW_ASSERT_SAME(a_miss_index, aclk, aresetn, (m_tvalid && !m_tuser[0]), (m_tdata[plw_pkg::SLOT_BITS-1:0] == '0), "miss with nonzero index")

endmodule

>>> sv/plw_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module plw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> sv/plw_ctrl.sv
// controller state machine: request handshake, scan sequencing, output valid
// depends on plw_pkg
module plw_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic [plw_pkg::OP_BITS-1:0]    s_op,
    input  logic                           m_tready,
    input  plw_pkg::plw_status_t           status,
    output logic                           s_tready,
    output logic                           m_tvalid,
    output plw_pkg::plw_cmd_t              cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_XFORM = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_SCORE = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;

    logic [2:0]                     state_reg, state_next;
    logic [plw_pkg::COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.accept     = s_tvalid && s_tready;
        cmd.issue_addr = cnt_reg[plw_pkg::ADDR_BITS-1:0];
        case (state_reg)
            S_IDLE: begin
                if (cmd.accept && (s_op == plw_pkg::OP_OBS)) begin
                    state_next = S_XFORM;
                end
            end
            S_XFORM: begin
                cmd.xform_en = 1'b1;
                cnt_next     = '0;
                if (status.scan_count == '0) begin
                    state_next = S_DRAIN;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.issue = 1'b1;
                cnt_next  = cnt_reg + plw_pkg::COUNT_BITS'(1);
                if (cnt_next == status.scan_count) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = S_SCORE;
                end
            end
            S_SCORE: begin
                cmd.score_en = 1'b1;
                state_next   = S_WRITE;
            end
            S_WRITE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/plw_datapath.sv
// datapath: config registers, landmark table, transform, scan pipeline, scoring
// depends on plw_pkg and plw_ram
module plw_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [plw_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [plw_pkg::CFG_DATA_BITS-1:0]   cfg_wr_data,
    input  logic [plw_pkg::OP_BITS-1:0]         s_op,
    input  logic [plw_pkg::IN_DATA_BITS-1:0]    s_tdata,
    input  logic                                s_tlast,
    input  plw_pkg::plw_cmd_t                   cmd,
    output plw_pkg::plw_status_t                status,
    output logic [plw_pkg::OUT_DATA_BITS-1:0]   m_tdata,
    output logic [0:0]                          m_tuser,
    output logic                                m_tlast
);

    localparam int CB = plw_pkg::COORD_BITS;
    localparam int AB = plw_pkg::ADDR_BITS;
    localparam int WB = plw_pkg::WIDE_BITS;
    localparam int LB = plw_pkg::LOG_BITS;

    // configuration
    logic [plw_pkg::LCOUNT_BITS-1:0]   landmark_count_reg;
    logic [plw_pkg::RANGE_BITS-1:0]    range_reg;
    logic [plw_pkg::COEF_BITS-1:0]     coef_x_reg, coef_y_reg;
    logic signed [LB-1:0]              log_norm_reg, miss_penalty_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            landmark_count_reg <= '0;
            range_reg          <= '0;
            coef_x_reg         <= '0;
            coef_y_reg         <= '0;
            log_norm_reg       <= '0;
            miss_penalty_reg   <= plw_pkg::MISS_PENALTY_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                plw_pkg::REG_LANDMARK_COUNT:
                    landmark_count_reg <= cfg_wr_data[plw_pkg::LCOUNT_BITS-1:0];
                plw_pkg::REG_RANGE_SQUARED:
                    range_reg <= cfg_wr_data[plw_pkg::RANGE_BITS-1:0];
                plw_pkg::REG_COEF_X: coef_x_reg <= cfg_wr_data[plw_pkg::COEF_BITS-1:0];
                plw_pkg::REG_COEF_Y: coef_y_reg <= cfg_wr_data[plw_pkg::COEF_BITS-1:0];
                plw_pkg::REG_LOG_NORM: log_norm_reg <= cfg_wr_data[LB-1:0];
                plw_pkg::REG_MISS_PENALTY: miss_penalty_reg <= cfg_wr_data[LB-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (int'(landmark_count_reg) > plw_pkg::MAX_LANDMARKS) begin
            status.scan_count = plw_pkg::COUNT_BITS'(plw_pkg::MAX_LANDMARKS);
        end else begin
            status.scan_count = plw_pkg::COUNT_BITS'(landmark_count_reg);
        end
    end

    // request fields
    logic [plw_pkg::SLOT_BITS-1:0]        f_slot;
    logic signed [CB-1:0]                 f_mark_x, f_mark_y, f_pose_x, f_pose_y;
    logic signed [CB-1:0]                 f_obs_x, f_obs_y;
    logic signed [plw_pkg::HEAD_BITS-1:0] f_cos, f_sin;

    assign f_slot   = s_tdata[plw_pkg::SLOT_LSB +: plw_pkg::SLOT_BITS];
    assign f_mark_x = s_tdata[plw_pkg::MARK_X_LSB +: CB];
    assign f_mark_y = s_tdata[plw_pkg::MARK_Y_LSB +: CB];
    assign f_pose_x = s_tdata[plw_pkg::POSE_X_LSB +: CB];
    assign f_pose_y = s_tdata[plw_pkg::POSE_Y_LSB +: CB];
    assign f_cos    = s_tdata[plw_pkg::COS_LSB +: plw_pkg::HEAD_BITS];
    assign f_sin    = s_tdata[plw_pkg::SIN_LSB +: plw_pkg::HEAD_BITS];
    assign f_obs_x  = s_tdata[plw_pkg::OBS_X_LSB +: CB];
    assign f_obs_y  = s_tdata[plw_pkg::OBS_Y_LSB +: CB];

    // landmark table, y in the upper half
    logic           ram_wr_en;
    logic [2*CB-1:0] ram_rd_data;

    assign ram_wr_en = cmd.accept && (s_op == plw_pkg::OP_LOAD)
                       && (int'(f_slot) < plw_pkg::MAX_LANDMARKS);

    plw_ram #(
        .WIDTH (2 * CB),
        .DEPTH (plw_pkg::MAX_LANDMARKS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (AB'(f_slot)),
        .wr_data ({f_mark_y, f_mark_x}),
        .rd_en   (cmd.issue),
        .rd_addr (cmd.issue_addr),
        .rd_data (ram_rd_data)
    );

    // particle state and accumulator
    logic signed [CB-1:0]                 particle_x_reg, particle_y_reg;
    logic signed [plw_pkg::HEAD_BITS-1:0] particle_cos_reg, particle_sin_reg;
    logic signed [LB-1:0]                 acc_reg, acc_next;

    // rotation products, captured when an observation is accepted
    logic signed [plw_pkg::PROD_BITS-1:0] p_xc_reg, p_ys_reg, p_xs_reg, p_yc_reg;
    logic                                 obs_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            particle_x_reg   <= '0;
            particle_y_reg   <= '0;
            particle_cos_reg <= '0;
            particle_sin_reg <= '0;
            acc_reg          <= '0;
        end else if (cmd.accept && (s_op == plw_pkg::OP_POSE)) begin
            particle_x_reg   <= f_pose_x;
            particle_y_reg   <= f_pose_y;
            particle_cos_reg <= f_cos;
            particle_sin_reg <= f_sin;
            acc_reg          <= '0;
        end else if (cmd.load_out) begin
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && (s_op == plw_pkg::OP_OBS)) begin
            p_xc_reg     <= f_obs_x * particle_cos_reg;
            p_ys_reg     <= f_obs_y * particle_sin_reg;
            p_xs_reg     <= f_obs_x * particle_sin_reg;
            p_yc_reg     <= f_obs_y * particle_cos_reg;
            obs_last_reg <= s_tlast;
        end
    end

    // map frame position, round half up then add pose
    logic signed [plw_pkg::PROD_BITS+1:0] sum_x, sum_y;
    logic signed [plw_pkg::SHIFT_BITS-1:0] rot_x, rot_y;
    logic signed [plw_pkg::MAP_BITS-1:0]  mx_reg, my_reg;

    always_comb begin
        sum_x = (plw_pkg::PROD_BITS+2)'(p_xc_reg) - (plw_pkg::PROD_BITS+2)'(p_ys_reg)
                + (plw_pkg::PROD_BITS+2)'(1 << (plw_pkg::FRAC_BITS - 1));
        sum_y = (plw_pkg::PROD_BITS+2)'(p_xs_reg) + (plw_pkg::PROD_BITS+2)'(p_yc_reg)
                + (plw_pkg::PROD_BITS+2)'(1 << (plw_pkg::FRAC_BITS - 1));
        rot_x = sum_x[plw_pkg::PROD_BITS+1:plw_pkg::FRAC_BITS];
        rot_y = sum_y[plw_pkg::PROD_BITS+1:plw_pkg::FRAC_BITS];
    end

    always_ff @(posedge aclk) begin
        if (cmd.xform_en) begin
            mx_reg <= plw_pkg::MAP_BITS'(rot_x) + plw_pkg::MAP_BITS'(particle_x_reg);
            my_reg <= plw_pkg::MAP_BITS'(rot_y) + plw_pkg::MAP_BITS'(particle_y_reg);
        end
    end

    // magnitude of a difference, clamped to 2^21
    function automatic logic [plw_pkg::CLAMP_BITS-1:0] clamp_mag(
        input logic signed [plw_pkg::DIFF_BITS-1:0] d
    );
        logic [plw_pkg::DIFF_BITS-1:0] m;
        m = d[plw_pkg::DIFF_BITS-1] ? -d : d;
        if (m > plw_pkg::DIFF_BITS'(1 << (plw_pkg::CLAMP_BITS - 1))) begin
            clamp_mag = plw_pkg::CLAMP_BITS'(1 << (plw_pkg::CLAMP_BITS - 1));
        end else begin
            clamp_mag = m[plw_pkg::CLAMP_BITS-1:0];
        end
    endfunction

    // scan pipeline: table read, clamp, square, compare
    logic                              v1_reg, v2_reg, v3_reg;
    logic [AB-1:0]                     idx1_reg, idx2_reg, idx3_reg;
    logic signed [CB-1:0]              lx, ly;
    logic signed [plw_pkg::DIFF_BITS-1:0] dx, dy;
    logic [plw_pkg::CLAMP_BITS-1:0]    mag_x_reg, mag_y_reg;
    logic [plw_pkg::SQ_BITS-1:0]       sq_x_reg, sq_y_reg;
    logic [plw_pkg::DIST_BITS-1:0]     dist_sum;
    logic                              hit_reg;
    logic [AB-1:0]                     best_idx_reg;
    logic [plw_pkg::DIST_BITS-1:0]     best_d_reg;
    logic [plw_pkg::SQ_BITS-1:0]       best_qx_reg, best_qy_reg;

    assign lx       = ram_rd_data[CB-1:0];
    assign ly       = ram_rd_data[2*CB-1:CB];
    assign dx       = plw_pkg::DIFF_BITS'(mx_reg) - plw_pkg::DIFF_BITS'(lx);
    assign dy       = plw_pkg::DIFF_BITS'(my_reg) - plw_pkg::DIFF_BITS'(ly);
    assign dist_sum = plw_pkg::DIST_BITS'(sq_x_reg) + plw_pkg::DIST_BITS'(sq_y_reg);

    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        idx1_reg  <= cmd.issue_addr;
        idx2_reg  <= idx1_reg;
        idx3_reg  <= idx2_reg;
        mag_x_reg <= clamp_mag(dx);
        mag_y_reg <= clamp_mag(dy);
        sq_x_reg  <= mag_x_reg * mag_x_reg;
        sq_y_reg  <= mag_y_reg * mag_y_reg;
    end

    // strict less-than keeps the lowest slot on equal distance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg      <= 1'b0;
            best_idx_reg <= '0;
        end else if (cmd.xform_en) begin
            hit_reg      <= 1'b0;
            best_idx_reg <= '0;
        end else if (v3_reg && (dist_sum <= plw_pkg::DIST_BITS'(range_reg))
                     && (!hit_reg || (dist_sum < best_d_reg))) begin
            hit_reg      <= 1'b1;
            best_idx_reg <= idx3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v3_reg && (dist_sum <= plw_pkg::DIST_BITS'(range_reg))
            && (!hit_reg || (dist_sum < best_d_reg))) begin
            best_d_reg  <= dist_sum;
            best_qx_reg <= sq_x_reg;
            best_qy_reg <= sq_y_reg;
        end
    end

    // scoring: weighted squares, then saturating accumulate
    logic [plw_pkg::SPROD_BITS-1:0]    sp_x_reg, sp_y_reg;
    logic [plw_pkg::QSUM_BITS-1:0]     qsum;
    logic signed [WB-1:0]              q_w, sum_w;

    always_ff @(posedge aclk) begin
        if (cmd.score_en) begin
            sp_x_reg <= best_qx_reg * coef_x_reg;
            sp_y_reg <= best_qy_reg * coef_y_reg;
        end
    end

    always_comb begin
        qsum = plw_pkg::QSUM_BITS'(sp_x_reg) + plw_pkg::QSUM_BITS'(sp_y_reg)
               + plw_pkg::ROUND_HALF;
        q_w  = WB'(qsum[plw_pkg::QSUM_BITS-1:plw_pkg::SCORE_SHIFT]);
        if (hit_reg) begin
            sum_w = WB'(acc_reg) + WB'(log_norm_reg) - q_w;
        end else begin
            sum_w = WB'(acc_reg) + WB'(miss_penalty_reg);
        end
        if ((sum_w[WB-1:LB-1] == '0) || (sum_w[WB-1:LB-1] == '1)) begin
            acc_next = sum_w[LB-1:0];
        end else if (sum_w[WB-1]) begin
            acc_next = {1'b1, {(LB-1){1'b0}}};
        end else begin
            acc_next = {1'b0, {(LB-1){1'b1}}};
        end
    end

    // output payload
    logic [plw_pkg::SLOT_BITS-1:0] out_index_reg;
    logic                          out_found_reg;
    logic [LB-1:0]                 out_weight_reg;
    logic                          out_last_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_index_reg  <= hit_reg ? plw_pkg::SLOT_BITS'(best_idx_reg) : '0;
            out_found_reg  <= hit_reg;
            out_weight_reg <= acc_next;
            out_last_reg   <= obs_last_reg;
        end
    end

    assign m_tdata = {{plw_pkg::OUT_PAD_BITS{1'b0}}, out_weight_reg, out_index_reg};
    assign m_tuser = out_found_reg;
    assign m_tlast = out_last_reg;

endmodule

>>> sim/particle_landmark_weight_tb.sv
// self-checking testbench for particle_landmark_weight: directed and random request
// streams against an in-bench scoring model; needs plw_pkg and the block's rtl only
`timescale 1ns / 100ps

module particle_landmark_weight_tb;
    import plw_pkg::*;

    localparam logic [OP_BITS-1:0]         OP_UNUSED     = 2'd3;
    localparam int                         ITEM_TARGET   = 1750;
    localparam int                         QUIET_AFTER   = 1500;
    localparam int                         PHASE_ITEMS   = 120;
    localparam int                         SETTLE_CYCLES = 100;
    localparam int                         CYCLE_LIMIT   = 1000000;
    localparam int                         REPORT_LINES  = 200;
    localparam logic [RANGE_BITS-1:0]      RANGE_MAX     = 41'h100_0000_0000;
    localparam logic signed [LOG_BITS-1:0] LOG_MIN       = 32'sh8000_0000;
    localparam logic signed [LOG_BITS-1:0] LOG_MAX       = 32'sh7fff_ffff;
    localparam longint                     CLAMP_MAG     = 64'sd1 << 21;

    // one request as the sender sees it, before packing onto the stream
    typedef struct packed {
        logic [OP_BITS-1:0]           op;
        logic [SLOT_BITS-1:0]         slot;
        logic signed [COORD_BITS-1:0] mark_x;
        logic signed [COORD_BITS-1:0] mark_y;
        logic signed [COORD_BITS-1:0] pose_x;
        logic signed [COORD_BITS-1:0] pose_y;
        logic signed [HEAD_BITS-1:0]  cos_h;
        logic signed [HEAD_BITS-1:0]  sin_h;
        logic signed [COORD_BITS-1:0] obs_x;
        logic signed [COORD_BITS-1:0] obs_y;
        logic                         last;
    } lm_request_t;

    typedef struct packed {
        logic [SLOT_BITS-1:0]       index;
        logic                       found;
        logic signed [LOG_BITS-1:0] weight;
        logic                       last;
    } weight_result_t;

    logic                      aclk        = 1'b0;
    logic                      aresetn     = 1'b0;
    logic                      cfg_wr_en   = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index   = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wr_data = '0;
    logic                      s_tvalid    = 1'b0;
    logic                      s_tready;
    logic [IN_DATA_BITS-1:0]   s_tdata     = '0;
    logic [OP_BITS-1:0]        s_tuser     = '0;
    logic                      s_tlast     = 1'b0;
    logic                      m_tvalid;
    logic                      m_tready    = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_tdata;
    logic [0:0]                m_tuser;
    logic                      m_tlast;

    particle_landmark_weight dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always #5 aclk = ~aclk;

    // scoring model state: landmark map, current particle, running log-weight
    longint          map_x [MAX_LANDMARKS];
    longint          map_y [MAX_LANDMARKS];
    longint          veh_x = 0, veh_y = 0, veh_cos = 0, veh_sin = 0;
    longint          weight_acc = 0;
    // model copy of the settings, reset values
    int              searched_count = 0;
    longint unsigned gate_dist_sq = 0;
    longint unsigned gain_x = 0, gain_y = 0;
    longint          norm_log = 0;
    longint          miss_log = MISS_PENALTY_RESET;

    lm_request_t     pending_requests[$];
    weight_result_t  expected_weights[$];
    lm_request_t     cur_req;
    bit              req_taken     = 1'b0;
    bit              sender_idle   = 1'b0;
    bit              receiver_idle = 1'b0;
    int              send_hold     = 0;
    int              recv_hold     = 0;
    int              mismatch_count = 0;
    int              random_items  = 0;
    int              cycle_count   = 0;

    function automatic longint unsigned clamp_square(input longint d);
        longint unsigned m;
        m = (d < 0) ? -d : d;
        if (m > CLAMP_MAG)
            m = CLAMP_MAG;
        return m * m;
    endfunction

    // advance the model by one accepted request; observations queue a result
    function automatic void weigh_request(input lm_request_t r);
        longint          mx, my, total;
        longint unsigned span_sq, best_sq, q;
        int              n, best, i;
        bit              hit;
        weight_result_t  res;
        case (r.op)
            OP_LOAD: begin
                map_x[r.slot] = r.mark_x;
                map_y[r.slot] = r.mark_y;
            end
            OP_POSE: begin
                veh_x      = r.pose_x;
                veh_y      = r.pose_y;
                veh_cos    = r.cos_h;
                veh_sin    = r.sin_h;
                weight_acc = 0;
            end
            OP_OBS: begin
                // rotate into map frame, round half up, then translate
                mx = ((longint'(r.obs_x) * veh_cos - longint'(r.obs_y) * veh_sin
                      + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS) + veh_x;
                my = ((longint'(r.obs_x) * veh_sin + longint'(r.obs_y) * veh_cos
                      + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS) + veh_y;
                n = (searched_count > MAX_LANDMARKS) ? MAX_LANDMARKS : searched_count;
                hit = 1'b0;
                best = 0;
                best_sq = 0;
                for (i = 0; i < n; i++) begin
                    span_sq = clamp_square(mx - map_x[i]) + clamp_square(my - map_y[i]);
                    // strict compare keeps the lowest slot on a tie
                    if (span_sq <= gate_dist_sq && (!hit || span_sq < best_sq)) begin
                        hit = 1'b1;
                        best = i;
                        best_sq = span_sq;
                    end
                end
                if (hit) begin
                    q = (clamp_square(mx - map_x[best]) * gain_x
                         + clamp_square(my - map_y[best]) * gain_y
                         + (64'd1 << (SCORE_SHIFT - 1))) >> SCORE_SHIFT;
                    total = weight_acc + norm_log - longint'(q);
                end else begin
                    total = weight_acc + miss_log;
                end
                if (total > longint'(LOG_MAX))
                    total = LOG_MAX;
                else if (total < longint'(LOG_MIN))
                    total = LOG_MIN;
                weight_acc = total;
                res.index  = hit ? SLOT_BITS'(best) : '0;
                res.found  = hit;
                res.weight = LOG_BITS'(weight_acc);
                res.last   = r.last;
                expected_weights = {expected_weights, res};
            end
            default: begin
            end
        endcase
    endfunction

    function automatic logic [IN_DATA_BITS-1:0] pack_request(input lm_request_t r);
        logic [IN_DATA_BITS-1:0] d;
        d = '0;
        d[SLOT_LSB   +: SLOT_BITS]  = r.slot;
        d[MARK_X_LSB +: COORD_BITS] = r.mark_x;
        d[MARK_Y_LSB +: COORD_BITS] = r.mark_y;
        d[POSE_X_LSB +: COORD_BITS] = r.pose_x;
        d[POSE_Y_LSB +: COORD_BITS] = r.pose_y;
        d[COS_LSB    +: HEAD_BITS]  = r.cos_h;
        d[SIN_LSB    +: HEAD_BITS]  = r.sin_h;
        d[OBS_X_LSB  +: COORD_BITS] = r.obs_x;
        d[OBS_Y_LSB  +: COORD_BITS] = r.obs_y;
        return d;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatch_count < REPORT_LINES)
            $display("%0t mismatch %s: got %0d, want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // fields a request does not use carry random bits
    function automatic lm_request_t noise_request();
        lm_request_t r;
        r.op     = OP_BITS'($urandom());
        r.slot   = SLOT_BITS'($urandom());
        r.mark_x = COORD_BITS'($urandom());
        r.mark_y = COORD_BITS'($urandom());
        r.pose_x = COORD_BITS'($urandom());
        r.pose_y = COORD_BITS'($urandom());
        r.cos_h  = HEAD_BITS'($urandom());
        r.sin_h  = HEAD_BITS'($urandom());
        r.obs_x  = COORD_BITS'($urandom());
        r.obs_y  = COORD_BITS'($urandom());
        r.last   = 1'($urandom());
        return r;
    endfunction

    function automatic void queue_load(input int slot, input int x, input int y);
        lm_request_t r;
        r = noise_request();
        r.op     = OP_LOAD;
        r.slot   = SLOT_BITS'(slot);
        r.mark_x = COORD_BITS'(x);
        r.mark_y = COORD_BITS'(y);
        pending_requests = {pending_requests, r};
    endfunction

    function automatic void queue_pose(input int x, input int y, input int c, input int s);
        lm_request_t r;
        r = noise_request();
        r.op     = OP_POSE;
        r.pose_x = COORD_BITS'(x);
        r.pose_y = COORD_BITS'(y);
        r.cos_h  = HEAD_BITS'(c);
        r.sin_h  = HEAD_BITS'(s);
        pending_requests = {pending_requests, r};
    endfunction

    function automatic void queue_obs(input int x, input int y, input bit last);
        lm_request_t r;
        r = noise_request();
        r.op    = OP_OBS;
        r.obs_x = COORD_BITS'(x);
        r.obs_y = COORD_BITS'(y);
        r.last  = last;
        pending_requests = {pending_requests, r};
    endfunction

    function automatic void queue_unused();
        lm_request_t r;
        r = noise_request();
        r.op = OP_UNUSED;
        pending_requests = {pending_requests, r};
    endfunction

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // vehicle-frame offset, now and then anywhere in the coordinate range
    function automatic int obs_offset(input int radius);
        if ($urandom_range(0, 14) == 0)
            return int'($urandom());
        return rand_between(-2 * radius, 2 * radius);
    endfunction

    // no request in flight, none queued, every result back, pipeline quiet
    task automatic await_idle();
        do
            @(negedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_weights.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
                                  input logic [CFG_DATA_BITS-1:0] value);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= index;
        cfg_wr_data <= value;
    endtask

    task automatic program_settings(input logic [LCOUNT_BITS-1:0] count,
                                     input logic [RANGE_BITS-1:0] gate,
                                     input logic [COEF_BITS-1:0] gx,
                                     input logic [COEF_BITS-1:0] gy,
                                     input logic signed [LOG_BITS-1:0] norm,
                                     input logic signed [LOG_BITS-1:0] miss);
        write_register(REG_LANDMARK_COUNT, CFG_DATA_BITS'(count));
        write_register(REG_RANGE_SQUARED, gate);
        write_register(REG_COEF_X, CFG_DATA_BITS'(gx));
        write_register(REG_COEF_Y, CFG_DATA_BITS'(gy));
        // upper data bits carry the sign extension and must be ignored
        write_register(REG_LOG_NORM, CFG_DATA_BITS'(norm));
        write_register(REG_MISS_PENALTY, CFG_DATA_BITS'(miss));
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        searched_count = int'(count);
        gate_dist_sq   = gate;
        gain_x         = gx;
        gain_y         = gy;
        norm_log       = norm;
        miss_log       = miss;
    endtask

    // one setting, a fresh landmark cluster, then particles with some noise
    task automatic run_random_phase(input bit quiet);
        logic [LCOUNT_BITS-1:0]     count;
        logic [RANGE_BITS-1:0]      gate;
        logic [COEF_BITS-1:0]       gx, gy;
        logic signed [LOG_BITS-1:0] norm, miss;
        int                         n, radius, reach, cx, cy, made, k, j, px, py, lx, ly;
        int                         c, s;
        bit                         last;
        real                        angle;
        case ($urandom_range(0, 7))
            0:       count = '0;
            1:       count = LCOUNT_BITS'(1);
            2:       count = LCOUNT_BITS'(MAX_LANDMARKS);
            3:       count = LCOUNT_BITS'($urandom_range(MAX_LANDMARKS + 1, 127));
            default: count = LCOUNT_BITS'($urandom_range(2, MAX_LANDMARKS - 1));
        endcase
        case ($urandom_range(0, 2))
            0:       radius = 64;
            1:       radius = 1024;
            default: radius = 8192;
        endcase
        case ($urandom_range(0, 9))
            0:       gate = '0;
            1:       gate = RANGE_MAX;
            2:       gate = RANGE_BITS'({8'($urandom()), 32'($urandom())});
            default: begin
                reach = $urandom_range(radius / 4, 4 * radius);
                gate  = RANGE_BITS'(longint'(reach) * reach);
            end
        endcase
        case ($urandom_range(0, 5))
            0:       gx = '0;
            1:       gx = '1;
            default: gx = COEF_BITS'($urandom());
        endcase
        case ($urandom_range(0, 5))
            0:       gy = '0;
            1:       gy = '1;
            default: gy = COEF_BITS'($urandom());
        endcase
        case ($urandom_range(0, 7))
            0:       norm = LOG_MIN;
            1:       norm = LOG_MAX;
            2:       norm = '0;
            default: norm = rand_between(-100000, 100000);
        endcase
        case ($urandom_range(0, 9))
            0:       miss = LOG_MIN;
            1:       miss = '0;
            2:       miss = rand_between(1, 5000);
            default: miss = -rand_between(0, 300000);
        endcase
        await_idle();
        program_settings(count, gate, gx, gy, norm, miss);
        if (quiet) begin
            sender_idle   = 1'b0;
            receiver_idle = 1'b0;
        end else begin
            sender_idle   = 1'($urandom());
            receiver_idle = 1'($urandom());
        end

        // every searched slot gets written before any observation reads it
        n  = (int'(count) > MAX_LANDMARKS) ? MAX_LANDMARKS : int'(count);
        cx = rand_between(-8000000, 8000000);
        cy = rand_between(-8000000, 8000000);
        lx = cx;
        ly = cy;
        made = 0;
        for (j = 0; j < n; j++) begin
            case ($urandom_range(0, 19))
                0: begin
                    lx = int'($urandom());
                    ly = int'($urandom());
                end
                1: begin
                    // repeat the previous landmark so two slots tie
                end
                default: begin
                    lx = cx + rand_between(-radius, radius);
                    ly = cy + rand_between(-radius, radius);
                end
            endcase
            queue_load(j, lx, ly);
            made++;
        end

        while (made < PHASE_ITEMS) begin
            case ($urandom_range(0, 19))
                0: queue_unused();
                1: begin
                    queue_load($urandom_range(0, MAX_LANDMARKS - 1),
                               cx + rand_between(-radius, radius),
                               cy + rand_between(-radius, radius));
                    made++;
                end
                2: begin
                    // observation that reuses the pose and weight already held
                    queue_obs(obs_offset(radius), obs_offset(radius), 1'($urandom()));
                    made++;
                end
                default: begin
                    if ($urandom_range(0, 19) == 0) begin
                        px = int'($urandom());
                        py = int'($urandom());
                    end else begin
                        px = cx + rand_between(-radius, radius);
                        py = cy + rand_between(-radius, radius);
                    end
                    case ($urandom_range(0, 9))
                        0: begin
                            c = int'($urandom());
                            s = int'($urandom());
                        end
                        1: begin
                            c = (($urandom_range(0, 1) == 0) ? 16384 : -16384);
                            s = 0;
                        end
                        default: begin
                            angle = $urandom_range(0, 62831) / 10000.0;
                            c = $rtoi($cos(angle) * 16384.0);
                            s = $rtoi($sin(angle) * 16384.0);
                        end
                    endcase
                    queue_pose(px, py, c, s);
                    k = $urandom_range(1, 6);
                    for (j = 0; j < k; j++) begin
                        last = (j == k - 1);
                        // a misplaced or missing end mark now and then
                        if ($urandom_range(0, 14) == 0)
                            last = ~last;
                        queue_obs(obs_offset(radius), obs_offset(radius), last);
                    end
                    made += 1 + k;
                end
            endcase
        end
        random_items += made;
    endtask

    // request side: new request on the falling edge once the last one is taken
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || req_taken) begin
                if (send_hold > 0) begin
                    send_hold--;
                    s_tvalid <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    cur_req = pending_requests.pop_front();
                    s_tdata  <= pack_request(cur_req);
                    s_tuser  <= cur_req.op;
                    s_tlast  <= cur_req.last;
                    s_tvalid <= 1'b1;
                    if (sender_idle && $urandom_range(0, 3) == 0)
                        send_hold = $urandom_range(1, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            req_taken = 1'b0;
        end
    end

    // result side backpressure in bursts
    always @(negedge aclk) begin
        if (aresetn) begin
            if (recv_hold > 0) begin
                recv_hold--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (receiver_idle && $urandom_range(0, 4) == 0)
                    recv_hold = $urandom_range(1, 9);
            end
        end
    end

    // both handshakes sampled on the rising edge
    always @(posedge aclk) begin
        weight_result_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                weigh_request(cur_req);
                req_taken = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                if (expected_weights.size() == 0) begin
                    report_mismatch("result with no observation pending",
                                    $signed(m_tdata[OUT_WEIGHT_LSB +: LOG_BITS]), 0);
                end else begin
                    want = expected_weights.pop_front();
                    if (m_tdata[OUT_INDEX_LSB +: SLOT_BITS] !== want.index)
                        report_mismatch("landmark_index", m_tdata[OUT_INDEX_LSB +: SLOT_BITS],
                                        want.index);
                    if (m_tuser[0] !== want.found)
                        report_mismatch("found", m_tuser[0], want.found);
                    if (m_tdata[OUT_WEIGHT_LSB +: LOG_BITS] !== want.weight)
                        report_mismatch("log_weight",
                                        $signed(m_tdata[OUT_WEIGHT_LSB +: LOG_BITS]),
                                        want.weight);
                    if (m_tlast !== want.last)
                        report_mismatch("is_last", m_tlast, want.last);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: empty search, default penalty, pose still at reset
        queue_obs(8388607, -8388608, 1'b0);
        queue_unused();
        queue_obs(-8388608, 8388607, 1'b1);
        queue_load(0, 8388607, -8388608);
        queue_load(1, 0, 0);
        queue_load(2, 0, 0);
        queue_load(3, -8388608, 8388607);
        queue_load(MAX_LANDMARKS - 1, -1, -1);

        // four slots, range 2^40: tie, near hit, clamped miss to the floor
        await_idle();
        program_settings(LCOUNT_BITS'(4), RANGE_MAX, '1, COEF_BITS'(1), 32'sd1000, LOG_MIN);
        sender_idle   = 1'b1;
        receiver_idle = 1'b1;
        queue_pose(0, 0, 16384, 0);
        queue_obs(0, 0, 1'b0);
        queue_obs(256, -256, 1'b0);
        queue_obs(8388607, 8388607, 1'b0);
        queue_obs(0, 0, 1'b1);
        // heading words beyond unit length
        queue_pose(-8388608, 8388607, -32768, 32767);
        queue_obs(1, -1, 1'b1);

        // zero range hits only an exact match; top normaliser saturates high
        await_idle();
        program_settings(LCOUNT_BITS'(1), '0, '0, '0, LOG_MAX, '0);
        queue_pose(8388607, -8388608, 16384, 0);
        queue_obs(0, 0, 1'b0);
        queue_obs(0, 0, 1'b0);
        queue_obs(1, 0, 1'b1);

        // positive miss penalty is added as it stands
        await_idle();
        program_settings('0, RANGE_BITS'(1), '0, '0, -32'sd1, 32'sd1000);
        queue_pose(0, 0, 0, -16384);
        queue_obs(5, 5, 1'b0);
        queue_obs(-5, -5, 1'b1);

        while (random_items < ITEM_TARGET)
            run_random_phase(random_items >= QUIET_AFTER);

        await_idle();
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+sv
sv/plw_pkg.sv
sv/plw_ram.sv
sv/plw_ctrl.sv
sv/plw_datapath.sv
sv/particle_landmark_weight.sv
sim/particle_landmark_weight_tb.sv
